@@ design/sgpm_pkg.sv @@
// shared types and constants of the sensor grid pixel mapper
`default_nettype none
package sgpm_pkg;

	localparam int COORD_W = 32;
	localparam int STEP_W  = 31;
	localparam int CNT_W   = 13;
	localparam int PIX_W   = 24;
	localparam int TAG_W   = 8;
	localparam int REM_W   = 32;
	localparam int Q_W     = 13;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 32;

	localparam int DEF_PIXEL_BASE     = 0;
	localparam int DEF_COL_SHIFT      = 0;
	localparam int DEF_ROW_SHIFT      = 0;
	localparam int DEF_GRID_TAG_VALUE = 1;
	localparam int DEF_FRAC_BITS      = 16;
	localparam int DEF_MAX_AXIS       = 4096;

	localparam logic [IDX_W-1:0] REG_X_ORIGIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_STEP      = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_PAD_WIDTH = 3'd2;
	localparam logic [IDX_W-1:0] REG_X_COUNT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_Y_ORIGIN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_STEP      = 3'd5;
	localparam logic [IDX_W-1:0] REG_Y_PAD_WIDTH = 3'd6;
	localparam logic [IDX_W-1:0] REG_Y_COUNT     = 3'd7;

	localparam logic REQ_POS   = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic                      req_type;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [PIX_W-1:0]          pixel_index;
	} req_t;

	typedef struct packed {
		logic                      hit_valid;
		logic [PIX_W-1:0]          pixel_out;
		logic [CNT_W-1:0]          column;
		logic [CNT_W-1:0]          row;
		logic [TAG_W-1:0]          grid_tag;
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_origin;
		logic [STEP_W-1:0]         x_step;
		logic [STEP_W-1:0]         x_pad_width;
		logic [CNT_W-1:0]          x_count;
		logic signed [COORD_W-1:0] y_origin;
		logic [STEP_W-1:0]         y_step;
		logic [STEP_W-1:0]         y_pad_width;
		logic [CNT_W-1:0]          y_count;
	} cfg_t;

	// effective pitch (never zero) and clamped counts
	typedef struct packed {
		logic [STEP_W-1:0] step_x;
		logic [STEP_W-1:0] step_y;
		logic [CNT_W-1:0]  cnt_x;
		logic [CNT_W-1:0]  cnt_y;
	} eff_t;

	typedef struct packed {
		logic             valid;
		logic             req_type;
		logic             reject;
		logic [PIX_W-1:0] pix;
		logic [REM_W-1:0] rem_x;
		logic [Q_W-1:0]   q_x;
		logic [REM_W-1:0] rem_y;
		logic [Q_W-1:0]   q_y;
	} stage_t;

endpackage
`default_nettype wire

@@ design/sgpm_front.sv @@
// front stages: offsets from the grid origin and range pre-checks
`default_nettype none
module sgpm_front
	import sgpm_pkg::*;
#(
	parameter int PIXEL_BASE = DEF_PIXEL_BASE,
	parameter int Q_BITS     = 12
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_valid,
	input  wire req_t   in_item,
	input  wire cfg_t   cfg,
	input  wire eff_t   eff,
	output stage_t      st_out
);

	logic                        v_s1;
	logic                        type_s1;
	logic signed [COORD_W:0]     dx_s1;
	logic signed [COORD_W:0]     dy_s1;
	logic [PIX_W-1:0]            pix_s1;
	logic                        pneg_s1;
	logic [PIX_W-1:0]            local_s1;

	logic signed [COORD_W:0]     dx;
	logic signed [COORD_W:0]     dy;
	logic [PIX_W-1:0]            base;
	stage_t                      st_n;
	logic                        ovf_x;
	logic                        ovf_y;
	logic                        ovf_p;

	assign base = PIX_W'(PIXEL_BASE);
	assign dx = $signed({in_item.pos_x[COORD_W-1], in_item.pos_x})
		- $signed({cfg.x_origin[COORD_W-1], cfg.x_origin});
	assign dy = $signed({in_item.pos_y[COORD_W-1], in_item.pos_y})
		- $signed({cfg.y_origin[COORD_W-1], cfg.y_origin});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1  <= in_item.req_type;
			dx_s1    <= dx;
			dy_s1    <= dy;
			pix_s1   <= in_item.pixel_index;
			pneg_s1  <= in_item.pixel_index < base;
			local_s1 <= in_item.pixel_index - base;
		end
	end

	// quotient would need more bits than the cell row provides
	assign ovf_x = (dx_s1[REM_W-1:0] >> Q_BITS) >= REM_W'(eff.step_x);
	assign ovf_y = (dy_s1[REM_W-1:0] >> Q_BITS) >= REM_W'(eff.step_y);
	assign ovf_p = (local_s1 >> Q_BITS) >= PIX_W'(eff.cnt_x);

	always_comb begin
		st_n          = '0;
		st_n.valid    = v_s1;
		st_n.req_type = type_s1;
		st_n.pix      = pix_s1;
		if (type_s1 == REQ_POS) begin
			st_n.reject = dx_s1[COORD_W] | dy_s1[COORD_W] | ovf_x | ovf_y;
			st_n.rem_x  = dx_s1[REM_W-1:0];
			st_n.rem_y  = dy_s1[REM_W-1:0];
		end else begin
			st_n.reject = pneg_s1 | (eff.cnt_x == '0) | ovf_p;
			st_n.rem_x  = REM_W'(local_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_out <= '0;
		end else if (en) begin
			st_out <= st_n;
		end
	end

endmodule
`default_nettype wire

@@ design/sgpm_cell.sv @@
// one restoring division cell: settles one quotient bit on both axes
`default_nettype none
module sgpm_cell
	import sgpm_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire eff_t   eff,
	input  wire stage_t st_in,
	output stage_t      st_out
);

	localparam int CW = REM_W + Q_W;

	logic [STEP_W-1:0] div_x;
	logic [CW-1:0]     sh_x;
	logic [CW-1:0]     sh_y;
	stage_t            st_n;

	// pixel requests divide the local number by the column count
	assign div_x = (st_in.req_type == REQ_PIXEL) ? STEP_W'(eff.cnt_x) : eff.step_x;
	assign sh_x  = CW'(div_x) << SHIFT;
	assign sh_y  = CW'(eff.step_y) << SHIFT;

	always_comb begin
		st_n = st_in;
		if (CW'(st_in.rem_x) >= sh_x) begin
			st_n.rem_x = st_in.rem_x - sh_x[REM_W-1:0];
			st_n.q_x   = st_in.q_x | (Q_W'(1) << SHIFT);
		end
		if (CW'(st_in.rem_y) >= sh_y) begin
			st_n.rem_y = st_in.rem_y - sh_y[REM_W-1:0];
			st_n.q_y   = st_in.q_y | (Q_W'(1) << SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_out <= '0;
		end else if (en) begin
			st_out <= st_n;
		end
	end

endmodule
`default_nettype wire

@@ design/sgpm_back.sv @@
// back stages: bound and pad gap tests, pixel number, pad centres, output register
`default_nettype none
module sgpm_back
	import sgpm_pkg::*;
#(
	parameter int PIXEL_BASE     = DEF_PIXEL_BASE,
	parameter int COL_SHIFT      = DEF_COL_SHIFT,
	parameter int ROW_SHIFT      = DEF_ROW_SHIFT,
	parameter int GRID_TAG_VALUE = DEF_GRID_TAG_VALUE
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire cfg_t   cfg,
	input  wire eff_t   eff,
	input  wire stage_t st_in,
	output logic        out_valid,
	output res_t        out_item
);

	localparam int PROD_W = CNT_W + STEP_W;
	localparam int SUM_W  = PROD_W + 2;

	logic                     v_s1;
	logic                     type_s1;
	logic                     rej_s1;
	logic [PIX_W-1:0]         pix_s1;
	logic [CNT_W-1:0]         col_s1;
	logic [CNT_W-1:0]         row_s1;
	logic signed [COORD_W:0]  devx_s1;
	logic signed [COORD_W:0]  devy_s1;
	logic [2*CNT_W-1:0]       ppix_s1;
	logic [PROD_W-1:0]        pcx_s1;
	logic [PROD_W-1:0]        pcy_s1;

	logic                     rej;
	logic [CNT_W-1:0]         col;
	logic [CNT_W-1:0]         row;
	logic signed [COORD_W:0]  devx;
	logic signed [COORD_W:0]  devy;

	logic [COORD_W:0]         absx;
	logic [COORD_W:0]         absy;
	logic                     gap;
	logic signed [SUM_W-1:0]  sum_x;
	logic signed [SUM_W-1:0]  sum_y;
	logic signed [COORD_W-1:0] cx;
	logic signed [COORD_W-1:0] cy;
	res_t                     res_n;
	logic                     rej_all;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32'sh7FFF_FFFF);
		lo = -SUM_W'(33'sh0_8000_0000);
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[COORD_W-1:0];
		end
	endfunction

	always_comb begin
		if (st_in.req_type == REQ_POS) begin
			col = st_in.q_x;
			row = st_in.q_y;
			rej = st_in.reject | (st_in.q_x >= eff.cnt_x) | (st_in.q_y >= eff.cnt_y);
		end else begin
			col = st_in.rem_x[CNT_W-1:0];
			row = st_in.q_x;
			rej = st_in.reject | (st_in.q_x >= eff.cnt_y);
		end
	end

	// step - 2*rem, rem is below the step
	assign devx = $signed({2'b00, eff.step_x}) - $signed({1'b0, st_in.rem_x[STEP_W-1:0], 1'b0});
	assign devy = $signed({2'b00, eff.step_y}) - $signed({1'b0, st_in.rem_y[STEP_W-1:0], 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= st_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= st_in.req_type;
			rej_s1  <= rej;
			pix_s1  <= st_in.pix;
			col_s1  <= col;
			row_s1  <= row;
			devx_s1 <= devx;
			devy_s1 <= devy;
			ppix_s1 <= row * eff.cnt_x;
			pcx_s1  <= col * eff.step_x;
			pcy_s1  <= row * eff.step_y;
		end
	end

	assign absx = devx_s1[COORD_W] ? (COORD_W+1)'(0) - devx_s1 : devx_s1;
	assign absy = devy_s1[COORD_W] ? (COORD_W+1)'(0) - devy_s1 : devy_s1;
	assign gap  = (absx > (COORD_W+1)'(cfg.x_pad_width))
		| (absy > (COORD_W+1)'(cfg.y_pad_width));

	// centre = origin + idx*step + floor(step/2)
	assign sum_x = SUM_W'(cfg.x_origin) + $signed(SUM_W'(pcx_s1))
		+ $signed(SUM_W'(eff.step_x >> 1));
	assign sum_y = SUM_W'(cfg.y_origin) + $signed(SUM_W'(pcy_s1))
		+ $signed(SUM_W'(eff.step_y >> 1));
	assign cx = sat32(sum_x);
	assign cy = sat32(sum_y);

	assign rej_all = rej_s1 | ((type_s1 == REQ_POS) & gap);

	always_comb begin
		res_n = '0;
		if (!rej_all) begin
			res_n.hit_valid = 1'b1;
			res_n.column    = col_s1 + CNT_W'(COL_SHIFT);
			res_n.row       = row_s1 + CNT_W'(ROW_SHIFT);
			res_n.grid_tag  = TAG_W'(GRID_TAG_VALUE);
			if (type_s1 == REQ_POS) begin
				res_n.pixel_out = PIX_W'(col_s1) + ppix_s1[PIX_W-1:0] + PIX_W'(PIXEL_BASE);
			end else begin
				res_n.pixel_out = pix_s1;
				res_n.centre_x  = cx;
				res_n.centre_y  = cy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= res_n;
		end
	end

endmodule
`default_nettype wire

@@ design/sensor_grid_pixel_mapper.sv @@
// top level of the sensor grid pixel mapper
// Maps hit positions to pixel numbers and pixel numbers to pad centres on one
// rectangular grid with Q15.16 coordinates.
// in_valid/in_ready carry one request item (req_t); out_valid/out_ready carry
// one result item (res_t) per request, in request order.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register per
// cycle; the user must write it only while no item is in flight, since the
// block does not enforce it. Items pass the front registers, the division cells
// and back registers; the pipeline takes one item every cycle unless stalled.
// The depth is set by the row of division cells, one cell per quotient bit,
// carrying both the x and the y quotient.
// The whole pipeline advances together: when the receiver holds out_ready low
// with a result waiting, every stage holds and in_ready drops.
// Reset clears all valid flags and loads the register defaults (origin 0,
// pitch and pad width 1.0, one column and one row).
`default_nettype none
module sensor_grid_pixel_mapper
	import sgpm_pkg::*;
#(
	parameter int PIXEL_BASE     = DEF_PIXEL_BASE,
	parameter int COL_SHIFT      = DEF_COL_SHIFT,
	parameter int ROW_SHIFT      = DEF_ROW_SHIFT,
	parameter int GRID_TAG_VALUE = DEF_GRID_TAG_VALUE,
	parameter int FRAC_BITS      = DEF_FRAC_BITS,
	parameter int MAX_AXIS       = DEF_MAX_AXIS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire req_t             in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output res_t                  out_item,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int Q_BITS = $clog2(MAX_AXIS);

	cfg_t   cfg_q;
	eff_t   eff;
	logic   en;
	stage_t st_chain [0:Q_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin    <= '0;
			cfg_q.x_step      <= STEP_W'(1) << FRAC_BITS;
			cfg_q.x_pad_width <= STEP_W'(1) << FRAC_BITS;
			cfg_q.x_count     <= CNT_W'(1);
			cfg_q.y_origin    <= '0;
			cfg_q.y_step      <= STEP_W'(1) << FRAC_BITS;
			cfg_q.y_pad_width <= STEP_W'(1) << FRAC_BITS;
			cfg_q.y_count     <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN:    cfg_q.x_origin    <= cfg_data;
				REG_X_STEP:      cfg_q.x_step      <= cfg_data[STEP_W-1:0];
				REG_X_PAD_WIDTH: cfg_q.x_pad_width <= cfg_data[STEP_W-1:0];
				REG_X_COUNT:     cfg_q.x_count     <= cfg_data[CNT_W-1:0];
				REG_Y_ORIGIN:    cfg_q.y_origin    <= cfg_data;
				REG_Y_STEP:      cfg_q.y_step      <= cfg_data[STEP_W-1:0];
				REG_Y_PAD_WIDTH: cfg_q.y_pad_width <= cfg_data[STEP_W-1:0];
				REG_Y_COUNT:     cfg_q.y_count     <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// a zero pitch acts as the smallest pitch, counts clamp at MAX_AXIS
	always_comb begin
		eff.step_x = (cfg_q.x_step == '0) ? STEP_W'(1) : cfg_q.x_step;
		eff.step_y = (cfg_q.y_step == '0) ? STEP_W'(1) : cfg_q.y_step;
		eff.cnt_x  = (cfg_q.x_count > CNT_W'(MAX_AXIS)) ? CNT_W'(MAX_AXIS) : cfg_q.x_count;
		eff.cnt_y  = (cfg_q.y_count > CNT_W'(MAX_AXIS)) ? CNT_W'(MAX_AXIS) : cfg_q.y_count;
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	sgpm_front #(
		.PIXEL_BASE (PIXEL_BASE),
		.Q_BITS     (Q_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.eff      (eff),
		.st_out   (st_chain[0])
	);

	// most significant quotient bit first
	for (genvar k = 0; k < Q_BITS; k++) begin : g_cell
		sgpm_cell #(
			.SHIFT (Q_BITS - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.eff    (eff),
			.st_in  (st_chain[k]),
			.st_out (st_chain[k+1])
		);
	end

	sgpm_back #(
		.PIXEL_BASE     (PIXEL_BASE),
		.COL_SHIFT      (COL_SHIFT),
		.ROW_SHIFT      (ROW_SHIFT),
		.GRID_TAG_VALUE (GRID_TAG_VALUE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.eff       (eff),
		.st_in     (st_chain[Q_BITS]),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.hit_valid |->
			out_item.pixel_out == '0 && out_item.column == '0 && out_item.row == '0
			&& out_item.grid_tag == '0 && out_item.centre_x == '0 && out_item.centre_y == '0)
		else $error("rejected item carries nonzero fields");

	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.hit_valid |-> out_item.grid_tag == TAG_W'(GRID_TAG_VALUE))
		else $error("grid tag mismatch");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.hit_valid |->
			out_item.column >= CNT_W'(COL_SHIFT) && out_item.row >= CNT_W'(ROW_SHIFT))
		else $error("column or row below its offset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(st_chain[0]))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire
